@@ design/dfdl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdl_pkg
// Shared types and codes of the doppler fractional delay line.
// ----------------------------------------------------------------------------
package dfdl_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam int RATE_BITS = 16;
  localparam int TGT_BITS  = 12;

  // Step direction, two's complement
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAP_A,
    PH_TAP_B
  } phase_e;

endpackage

@@ design/doppler_fractional_delay_line_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_fractional_delay_line_unit
// Ring-buffer delay line with a tap that glides toward a target delay and a
// linear mix of the two neighbouring taps.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_stall   opcode, sample_in, target_delay
// out      out  out_valid/out_stall sample_out, gliding
// cfg      in   cfg_valid/cfg_ready glide_rate
//
// A sample word passes the sequencer phases TAP_A and TAP_B: both taps are
// read through the single read port of the sample RAM. A set-delay word
// uses TAP_A only. The mix result is registered into a 2-word output queue.
// Unwritten RAM entries read as zero via the write pointer fill mark, so no
// clearing pass is needed after reset.
// in_stall rises on a busy sequencer or two results in flight with none taken.
// ----------------------------------------------------------------------------
module doppler_fractional_delay_line_unit #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 opcode_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  logic [dfdl_pkg::TGT_BITS-1:0]        target_delay_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o,
  output logic                                 gliding_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dfdl_pkg::RATE_BITS-1:0]       cfg_data_i
);
  import dfdl_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = (AW > TGT_BITS) ? AW : TGT_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = SB + 18;
  localparam int ACW = SB + 19;
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

  // item register
  phase_e            phase_q, phase_d;
  logic              op_q;
  logic signed [SB-1:0] smp_q;
  logic [TGT_BITS-1:0]  tgt_q;

  // delay line state
  logic [AW-1:0]        wp_q, wp_d;
  logic                 wrapped_q, wrapped_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [AW-1:0]        goal_q, goal_d;
  logic [RATE_BITS-1:0] frac_q, frac_d;
  logic                 moving_q, moving_d;
  logic [1:0]           dir_q, dir_d;
  logic [RATE_BITS-1:0] rate_q;

  // mix pipeline
  logic                 a_ok_q, b_ok_q;
  logic signed [PW-1:0] pa_q;
  logic [RATE_BITS-1:0] mixf_q;
  logic                 mix_vld_q;
  logic                 mix_gl_q;

  // output queue
  logic                 hd_v_q, hd_v_d, tl_v_q, tl_v_d;
  logic signed [SB-1:0] hd_smp_q, hd_smp_d, tl_smp_q, tl_smp_d;
  logic                 hd_gl_q, hd_gl_d, tl_gl_q, tl_gl_d;
  logic [1:0]           cnt_q, cnt_d;

  logic                 seq_free, in_fire, out_take;
  logic [AW-1:0]        raddr, nb_idx, tgt_clamp, cur_step;
  logic [SB-1:0]        rdata;
  logic                 rd_ok;
  logic [RATE_BITS:0]   frac_sum;
  logic signed [SB-1:0] a_smp, b_smp;
  logic [RATE_BITS-1:0] mixf;
  logic [RATE_BITS:0]   wa;
  logic signed [PW-1:0] pa_d, pb;
  logic signed [ACW-1:0] acc;
  logic signed [SB-1:0] mix_res;

  function automatic logic [AW-1:0] tap_idx(input logic [AW-1:0] wp, input logic [AW-1:0] d);
    logic [AW:0] diff;
    diff = {1'b0, wp} - (AW+1)'(1) - {1'b0, d};
    if (diff[AW]) begin
      diff = diff + (AW+1)'(STORE_DEPTH);
    end
    return diff[AW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // handshake
  assign out_valid_o  = hd_v_q;
  assign sample_out_o = hd_smp_q;
  assign gliding_o    = hd_gl_q;
  assign out_take     = hd_v_q & ~out_stall_i;

  assign seq_free = (phase_q == PH_IDLE) || (phase_q == PH_TAP_B) ||
                    ((phase_q == PH_TAP_A) && (op_q == OP_SET));
  assign in_stall_o = ~(seq_free && ((cnt_q < 2'd2) || out_take));
  assign in_fire    = in_valid_i & ~in_stall_o;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    if (in_fire) begin
      phase_d = PH_TAP_A;
    end else if ((phase_q == PH_TAP_A) && (op_q == OP_PUSH)) begin
      phase_d = PH_TAP_B;
    end else begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_i;
      smp_q <= sample_in_i;
      tgt_q <= target_delay_i;
    end
  end

  // tap addresses
  always_comb begin
    if ((dir_q == DIR_UP) && (cur_q != LAST_IDX)) begin
      nb_idx = cur_q + AW'(1);
    end else if ((dir_q == DIR_DOWN) && (cur_q != '0)) begin
      nb_idx = cur_q - AW'(1);
    end else begin
      nb_idx = cur_q;
    end
    raddr = (phase_q == PH_TAP_B) ? tap_idx(wp_q, nb_idx) : tap_idx(wp_q, cur_q);
    rd_ok = wrapped_q || (raddr < wp_q);
  end

  dfdl_ram #(
    .WIDTH (SB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (phase_q == PH_TAP_B),
    .waddr_i (wp_q),
    .wdata_i (smp_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // state update
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    cur_d     = cur_q;
    goal_d    = goal_q;
    frac_d    = frac_q;
    moving_d  = moving_q;
    dir_d     = dir_q;
    tgt_clamp = (CW'(tgt_q) > CW'(STORE_DEPTH - 1)) ? LAST_IDX : AW'(tgt_q);
    frac_sum  = {1'b0, frac_q} + {1'b0, rate_q};
    cur_step  = cur_q;
    if ((dir_q == DIR_UP) && (cur_q != LAST_IDX)) begin
      cur_step = cur_q + AW'(1);
    end else if ((dir_q == DIR_DOWN) && (cur_q != '0)) begin
      cur_step = cur_q - AW'(1);
    end
    if ((phase_q == PH_TAP_A) && (op_q == OP_SET)) begin
      cur_d    = goal_q;
      goal_d   = tgt_clamp;
      frac_d   = '0;
      moving_d = 1'b1;
      if (tgt_clamp > goal_q) begin
        dir_d = DIR_UP;
      end else if (tgt_clamp < goal_q) begin
        dir_d = DIR_DOWN;
      end else begin
        dir_d = DIR_NONE;
      end
    end else if (phase_q == PH_TAP_B) begin
      if (wp_q == LAST_IDX) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + AW'(1);
      end
      if (moving_q) begin
        frac_d = frac_sum[RATE_BITS-1:0];
        if (frac_sum[RATE_BITS]) begin
          cur_d = cur_step;
        end
        moving_d = (cur_d != goal_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      cur_q     <= '0;
      goal_q    <= '0;
      frac_q    <= '0;
      moving_q  <= 1'b0;
      dir_q     <= DIR_NONE;
    end else begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      cur_q     <= cur_d;
      goal_q    <= goal_d;
      frac_q    <= frac_d;
      moving_q  <= moving_d;
      dir_q     <= dir_d;
    end
  end

  // mix: first product when tap a lands, second with tap b
  assign a_smp = a_ok_q ? $signed(rdata) : '0;
  assign b_smp = b_ok_q ? $signed(rdata) : '0;
  assign mixf  = moving_q ? frac_q : '0;
  assign wa    = 17'h10000 - {1'b0, mixf};
  assign pa_d  = a_smp * $signed({1'b0, wa});
  assign pb    = b_smp * $signed({2'b00, mixf_q});
  assign acc   = ACW'(pa_q) + ACW'(pb);
  assign mix_res = acc[SB+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_vld_q <= 1'b0;
    end else begin
      mix_vld_q <= (phase_q == PH_TAP_B);
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_TAP_A) begin
      a_ok_q <= rd_ok;
    end
    if (phase_q == PH_TAP_B) begin
      b_ok_q   <= rd_ok;
      pa_q     <= pa_d;
      mixf_q   <= mixf;
      mix_gl_q <= moving_d;
    end
  end

  // output queue
  always_comb begin
    hd_v_d   = hd_v_q;
    hd_smp_d = hd_smp_q;
    hd_gl_d  = hd_gl_q;
    tl_v_d   = tl_v_q;
    tl_smp_d = tl_smp_q;
    tl_gl_d  = tl_gl_q;
    if (out_take) begin
      if (tl_v_q) begin
        hd_smp_d = tl_smp_q;
        hd_gl_d  = tl_gl_q;
        tl_v_d   = mix_vld_q;
        tl_smp_d = mix_res;
        tl_gl_d  = mix_gl_q;
      end else begin
        hd_v_d   = mix_vld_q;
        hd_smp_d = mix_res;
        hd_gl_d  = mix_gl_q;
      end
    end else if (mix_vld_q) begin
      if (!hd_v_q) begin
        hd_v_d   = 1'b1;
        hd_smp_d = mix_res;
        hd_gl_d  = mix_gl_q;
      end else begin
        tl_v_d   = 1'b1;
        tl_smp_d = mix_res;
        tl_gl_d  = mix_gl_q;
      end
    end
    cnt_d = cnt_q + ((in_fire && (opcode_i == OP_PUSH)) ? 2'd1 : 2'd0)
                  - (out_take ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_v_q <= 1'b0;
      tl_v_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      hd_v_q <= hd_v_d;
      tl_v_q <= tl_v_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_smp_q <= hd_smp_d;
    hd_gl_q  <= hd_gl_d;
    tl_smp_q <= tl_smp_d;
    tl_gl_q  <= tl_gl_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("in-flight count above queue depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mix_vld_q && hd_v_q && tl_v_q && !out_take))
    else $error("result pushed into full output queue");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tl_v_q |-> hd_v_q)
    else $error("queue tail valid without head");

  a_mix_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_vld_q |-> $past(phase_q == PH_TAP_B))
    else $error("mix result without second tap read");

  a_rest_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> (cur_q == goal_q))
    else $error("tap at rest away from goal");

endmodule

@@ design/dfdl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdl_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module dfdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
